>>> rtl/core/ogru_pkg.sv
// Shared types, codes and the control-store program of the ray update sequencer.
package ogru_pkg;

  localparam int PcW = 4;

  // Item selector codes
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Cell classes
  localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
  localparam logic [1:0] CLS_FREE     = 2'd1;
  localparam logic [1:0] CLS_OCCUPIED = 2'd2;
  localparam logic [1:0] CLS_FRONTIER = 2'd3;

  // Step addresses of the program
  localparam logic [PcW-1:0] PC_IDLE     = 4'd0;
  localparam logic [PcW-1:0] PC_FWD_INIT = 4'd1;
  localparam logic [PcW-1:0] PC_FWD_CELL = 4'd2;
  localparam logic [PcW-1:0] PC_FWD_NBP  = 4'd3;
  localparam logic [PcW-1:0] PC_FWD_NBM  = 4'd4;
  localparam logic [PcW-1:0] PC_BWD_INIT = 4'd5;
  localparam logic [PcW-1:0] PC_BWD_CELL = 4'd6;
  localparam logic [PcW-1:0] PC_BWD_NBP  = 4'd7;
  localparam logic [PcW-1:0] PC_BWD_NBM  = 4'd8;
  localparam logic [PcW-1:0] PC_EMIT     = 4'd9;
  localparam logic [PcW-1:0] PC_RD_ISSUE = 4'd10;
  localparam logic [PcW-1:0] PC_RD_TAKE  = 4'd11;
  localparam logic [PcW-1:0] PC_CLEAR    = 4'd12;
  localparam logic [PcW-1:0] PC_WIPE     = 4'd13;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_FWD_INIT,
    OP_BWD_INIT,
    OP_CELL,
    OP_NBP,
    OP_NBM,
    OP_RD_ISSUE,
    OP_RD_TAKE,
    OP_SWEEP,
    OP_EMIT
  } ogru_op_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_RAY,
    BR_SWEEP
  } ogru_br_e;

  typedef struct packed {
    ogru_op_e       op;
    ogru_br_e       br;
    logic [PcW-1:0] target;
  } ogru_uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic       accept;
    logic [1:0] func;
    logic       pos_ok;
    logic       ray_end;
    logic       sweep_last;
  } ogru_stat_t;

  function automatic ogru_uword_t ogru_ucode(input logic [PcW-1:0] pc);
    ogru_uword_t uw;
    unique case (pc)
      PC_IDLE:     uw = '{op: OP_LOAD,     br: BR_DISPATCH, target: PC_IDLE};
      PC_FWD_INIT: uw = '{op: OP_FWD_INIT, br: BR_NEXT,     target: PC_IDLE};
      PC_FWD_CELL: uw = '{op: OP_CELL,     br: BR_RAY,      target: PC_BWD_INIT};
      PC_FWD_NBP:  uw = '{op: OP_NBP,      br: BR_NEXT,     target: PC_IDLE};
      PC_FWD_NBM:  uw = '{op: OP_NBM,      br: BR_JUMP,     target: PC_FWD_CELL};
      PC_BWD_INIT: uw = '{op: OP_BWD_INIT, br: BR_NEXT,     target: PC_IDLE};
      PC_BWD_CELL: uw = '{op: OP_CELL,     br: BR_RAY,      target: PC_EMIT};
      PC_BWD_NBP:  uw = '{op: OP_NBP,      br: BR_NEXT,     target: PC_IDLE};
      PC_BWD_NBM:  uw = '{op: OP_NBM,      br: BR_JUMP,     target: PC_BWD_CELL};
      PC_EMIT:     uw = '{op: OP_EMIT,     br: BR_JUMP,     target: PC_IDLE};
      PC_RD_ISSUE: uw = '{op: OP_RD_ISSUE, br: BR_NEXT,     target: PC_IDLE};
      PC_RD_TAKE:  uw = '{op: OP_RD_TAKE,  br: BR_JUMP,     target: PC_EMIT};
      PC_CLEAR:    uw = '{op: OP_SWEEP,    br: BR_SWEEP,    target: PC_EMIT};
      PC_WIPE:     uw = '{op: OP_SWEEP,    br: BR_SWEEP,    target: PC_IDLE};
      default:     uw = '{op: OP_LOAD,     br: BR_JUMP,     target: PC_IDLE};
    endcase
    return uw;
  endfunction

endpackage

>>> rtl/core/ogru_if.sv
// Request and response channel interfaces of the occupancy grid ray update block.
interface ogru_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] pos_x;
  logic [3:0] pos_y;
  logic       horizontal;
  logic [7:0] dist_right;
  logic [7:0] dist_left;

  modport source (
    output valid, func, pos_x, pos_y, horizontal, dist_right, dist_left,
    input  ready
  );
  modport sink (
    input  valid, func, pos_x, pos_y, horizontal, dist_right, dist_left,
    output ready
  );
endinterface

interface ogru_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] cell_class;
  logic       bad_position;

  modport source (
    output valid, cell_class, bad_position,
    input  ready
  );
  modport sink (
    input  valid, cell_class, bad_position,
    output ready
  );
endinterface

>>> rtl/core/ogru_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module ogru_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ogru_pkg::ogru_stat_t stat_i,
  output ogru_pkg::ogru_op_e   op_o
);
  import ogru_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ogru_uword_t    uw;

  assign uw   = ogru_ucode(pc_q);
  assign op_o = uw.op;

  always_comb begin
    pc_d = pc_q;
    unique case (uw.br)
      BR_NEXT: pc_d = pc_q + PcW'(1);
      BR_JUMP: pc_d = uw.target;
      BR_DISPATCH: begin
        if (stat_i.accept) begin
          case (stat_i.func)
            FUNC_UPDATE: pc_d = stat_i.pos_ok ? PC_FWD_INIT : PC_EMIT;
            FUNC_READ:   pc_d = stat_i.pos_ok ? PC_RD_ISSUE : PC_EMIT;
            FUNC_CLEAR:  pc_d = PC_CLEAR;
            default:     pc_d = PC_EMIT;
          endcase
        end
      end
      BR_RAY:   pc_d = stat_i.ray_end ? uw.target : pc_q + PcW'(1);
      // hold on the sweep step until the last entry is written
      BR_SWEEP: pc_d = stat_i.sweep_last ? uw.target : pc_q;
      default:  pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WIPE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> rtl/core/occupancy_grid_ray_update.sv
// Top level of the occupancy grid ray update block: datapath, cell store, output register.
// Usage
//   req_i carries one item per beat: func selects a sensor update (ray walk), a single
//   cell read or a whole-map clear. rsp_o returns exactly one beat per item: the class
//   of the read cell (zero for other items) and a flag for a position outside the grid.
//   Items are processed one at a time by a microcoded sequencer driving one write port
//   and one registered read port of the cell store.
// Step sequence
//   Read: the issue, take and emit steps lie between the accepting edge and the response beat.
//   Update: a cell, a plus-neighbour and a minus-neighbour step per free cell on the ray
//   (base cell included), a cell step at each ray end, the forward and backward init steps
//   and the emit step; each free cell needs two read-modify-write accesses for its
//   neighbours through the single read port.
//   Clear: the sweep over all GRID_SIDE * GRID_SIDE cells, one cell written per cycle, then emit.
//   Bad position or unused selector: straight to the emit step.
// Reset
//   After reset the sweep writes every cell to unknown, during which req_i.ready stays low.
// Stalls
//   The response sits in an output register; the next item is accepted no earlier than
//   the edge that takes that beat, so a stalled receiver holds the input off.
module occupancy_grid_ray_update #(
  parameter int GRID_SIDE = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ogru_req_if.sink        req_i,
  ogru_rsp_if.source      rsp_o
);
  import ogru_pkg::*;

  localparam int Cells = GRID_SIDE * GRID_SIDE;
  localparam int IW    = $clog2(GRID_SIDE);
  localparam int AW    = $clog2(Cells);
  localparam int XW    = (GRID_SIDE > 15) ? $clog2(GRID_SIDE + 1) : 4;
  localparam int CW    = XW + 1;
  localparam logic signed [CW-1:0] SideC = CW'(GRID_SIDE);

  function automatic logic on_grid(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
    return !x[CW-1] && (x < SideC) && !y[CW-1] && (y < SideC);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y);
    logic [AW-1:0] a;
    a = AW'(AW'(y[IW-1:0]) * AW'(GRID_SIDE)) + AW'(x[IW-1:0]);
    return a;
  endfunction

  ogru_op_e   op;
  ogru_stat_t stat;

  logic req_fire;
  logic pos_ok;

  logic signed [CW-1:0] px_q, py_q, cur_x_q, cur_y_q;
  logic signed [CW-1:0] nbp_x, nbp_y, nbm_x, nbm_y;
  logic                 horiz_q, back_q;
  logic [7:0]           dr_q, dl_q, len_q;
  logic [8:0]           d_q;
  logic [1:0]           cls_q;
  logic                 bad_q;
  logic                 out_valid_q;
  logic [AW-1:0]        sweep_q;

  logic                 cur_in, nbp_in, nbm_in, ray_end, sweep_last;

  logic [1:0]           mem [Cells];
  logic                 mem_we;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [1:0]           mem_wd, rdata_q;

  // Handshake
  assign req_i.ready = (op == OP_LOAD) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign pos_ok      = (CW'(req_i.pos_x) < SideC) && (CW'(req_i.pos_y) < SideC);

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.cell_class   = cls_q;
  assign rsp_o.bad_position = bad_q;

  // Ray geometry: neighbours lie perpendicular to the ray axis
  assign nbp_x = horiz_q ? cur_x_q : cur_x_q + CW'(1);
  assign nbp_y = horiz_q ? cur_y_q + CW'(1) : cur_y_q;
  assign nbm_x = horiz_q ? cur_x_q : cur_x_q - CW'(1);
  assign nbm_y = horiz_q ? cur_y_q - CW'(1) : cur_y_q;

  assign cur_in     = on_grid(cur_x_q, cur_y_q);
  assign nbp_in     = on_grid(nbp_x, nbp_y);
  assign nbm_in     = on_grid(nbm_x, nbm_y);
  assign ray_end    = !cur_in || (d_q > {1'b0, len_q});
  assign sweep_last = (sweep_q == AW'(Cells - 1));

  assign stat = '{accept: req_fire, func: req_i.func, pos_ok: pos_ok,
                  ray_end: ray_end, sweep_last: sweep_last};

  ogru_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  // Cell store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cell_addr(cur_x_q, cur_y_q);
    mem_wd = CLS_FREE;
    mem_ra = cell_addr(nbp_x, nbp_y);
    unique case (op)
      OP_CELL: begin
        // free cell inside the ray, occupied at its end if still on the grid
        if (!ray_end) begin
          mem_we = 1'b1;
        end else begin
          mem_we = cur_in;
          mem_wd = CLS_OCCUPIED;
        end
      end
      OP_NBP: begin
        mem_we = nbp_in && (rdata_q == CLS_UNKNOWN);
        mem_wa = cell_addr(nbp_x, nbp_y);
        mem_wd = CLS_FRONTIER;
        mem_ra = cell_addr(nbm_x, nbm_y);
      end
      OP_NBM: begin
        mem_we = nbm_in && (rdata_q == CLS_UNKNOWN);
        mem_wa = cell_addr(nbm_x, nbm_y);
        mem_wd = CLS_FRONTIER;
      end
      OP_RD_ISSUE: begin
        mem_ra = cell_addr(px_q, py_q);
      end
      OP_SWEEP: begin
        mem_we = 1'b1;
        mem_wa = sweep_q;
        mem_wd = CLS_UNKNOWN;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[mem_ra];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sweep_q     <= '0;
    end else begin
      if (op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (op == OP_SWEEP) begin
        sweep_q <= sweep_last ? '0 : sweep_q + AW'(1);
      end
    end
  end

  // Item and ray registers
  always_ff @(posedge clk_i) begin
    unique case (op)
      OP_LOAD: begin
        if (req_fire) begin
          px_q    <= CW'(req_i.pos_x);
          py_q    <= CW'(req_i.pos_y);
          horiz_q <= req_i.horizontal;
          dr_q    <= req_i.dist_right;
          dl_q    <= req_i.dist_left;
          cls_q   <= CLS_UNKNOWN;
          bad_q   <= ((req_i.func == FUNC_UPDATE) || (req_i.func == FUNC_READ)) && !pos_ok;
        end
      end
      OP_FWD_INIT: begin
        cur_x_q <= px_q;
        cur_y_q <= py_q;
        d_q     <= '0;
        len_q   <= dr_q;
        back_q  <= 1'b0;
      end
      OP_BWD_INIT: begin
        cur_x_q <= horiz_q ? px_q - CW'(1) : px_q;
        cur_y_q <= horiz_q ? py_q : py_q - CW'(1);
        d_q     <= 9'd1;
        len_q   <= dl_q;
        back_q  <= 1'b1;
      end
      OP_NBM: begin
        // advance one cell along the ray
        if (horiz_q) begin
          cur_x_q <= back_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
        end else begin
          cur_y_q <= back_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
        end
        d_q <= d_q + 9'd1;
      end
      OP_RD_TAKE: begin
        cls_q <= rdata_q;
      end
      default: begin
        d_q <= d_q;
      end
    endcase
  end

  // Checks
  a_no_accept_while_writing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !req_fire
  ) else $error("item accepted while the cell store is being written");

  a_emit_into_empty_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (op == OP_EMIT) |-> !out_valid_q
  ) else $error("response formed while the previous beat is still pending");

  a_ray_step_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (op == OP_CELL) |-> (d_q <= ({1'b0, len_q} + 9'd1))
  ) else $error("ray walk ran past its end cell");

endmodule
